// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape core.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_EOI  = 2'd2;
    localparam logic [1:0] ST_ESC  = 2'd3;

    // One decoded input byte: up to four output bytes sharing a status.
    typedef struct packed {
        logic [1:0]      status;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } jsu_entry_t;

endpackage

// ===== rtl/core/json_string_unescape_to_utf8_core.sv =====
// Takes a JSON string body one byte per transfer (starting after the opening
// quote) and returns the decoded UTF-8 bytes, one per transfer, each with a
// status code; tlast marks the final output byte caused by one input byte.
// A new input byte is taken every cycle while the entry queue has room; the
// output moves one byte per cycle while m_axis_tready is high, so a \u escape
// that expands to two, three or four UTF-8 bytes holds the output for each
// byte while the FIFO_DEPTH-entry queue absorbs the burst. Decoded entries
// pass through the queue and the registered output stage. After a closing
// quote or an error the core drops input until a byte with string_start set.
// ----------------------------------------------------------------------------
// json_string_unescape_to_utf8_core
// Top level: escape decoder, entry queue and byte serialiser.
// ----------------------------------------------------------------------------
module json_string_unescape_to_utf8_core
    import jsu_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0] s_axis_tuser,   // [0] string_start, [1] end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] status
    output logic       m_axis_tlast
);

    logic       accept;
    logic       push, pop, full, head_valid;
    jsu_entry_t push_entry, head_entry;

    assign s_axis_tready = ~full;
    assign accept        = s_axis_tvalid & s_axis_tready;

    jsu_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (s_axis_tdata),
        .string_start (s_axis_tuser[0]),
        .end_of_text  (s_axis_tuser[1]),
        .push         (push),
        .push_entry   (push_entry)
    );

    jsu_queue #(.DEPTH(FIFO_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push & accept),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    jsu_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_DATA) |-> m_axis_tlast)
        else $error("status transfer not marked last");

    a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_DATA) |-> (m_axis_tdata == 8'h00))
        else $error("status transfer carries a non-zero byte");

    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("queue full while output stage empty");
`endif

endmodule

// ===== rtl/core/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one raw byte per transfer and, when the byte completes
// an item, produces one queue entry holding its UTF-8 bytes or status.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       string_start,
    input  logic       end_of_text,
    output logic       push,
    output jsu_entry_t push_entry
);

    localparam logic [2:0] MODE_BODY    = 3'd0;
    localparam logic [2:0] MODE_ESCAPE  = 3'd1;
    localparam logic [2:0] MODE_HEX     = 3'd2;
    localparam logic [2:0] MODE_WANT_BS = 3'd3;
    localparam logic [2:0] MODE_WANT_U  = 3'd4;
    localparam logic [2:0] MODE_HEX_LOW = 3'd5;
    localparam logic [2:0] MODE_HALTED  = 3'd6;

    logic [2:0]  mode_reg, mode_next, mode_cur;
    logic [1:0]  cnt_reg, cnt_next, cnt_cur;
    logic [15:0] cu_reg, cu_next, cu_cur;
    logic [15:0] hh_reg, hh_next, hh_cur;
    logic        bad_reg, bad_next, bad_cur;

    logic [3:0]  nib;
    logic        nib_ok;
    logic [15:0] cu_dig;
    logic        bad_dig;
    logic [20:0] cp_pair;

    function automatic jsu_entry_t utf8_enc(input logic [20:0] cp);
        jsu_entry_t e;
        e = '0;
        e.status = ST_DATA;
        if (cp <= 21'h7F) begin
            e.last_idx = 2'd0;
            e.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            e.last_idx = 2'd1;
            e.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            e.last_idx = 2'd2;
            e.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
            e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            e.last_idx = 2'd3;
            e.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
            e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

    function automatic jsu_entry_t fail_entry(input logic [1:0] st);
        jsu_entry_t e;
        e = '0;
        e.status = st;
        return e;
    endfunction

    assign mode_cur = string_start ? MODE_BODY : mode_reg;
    assign cnt_cur  = string_start ? 2'd0      : cnt_reg;
    assign cu_cur   = string_start ? 16'h0000  : cu_reg;
    assign hh_cur   = string_start ? 16'h0000  : hh_reg;
    assign bad_cur  = string_start ? 1'b0      : bad_reg;

    always_comb
    begin
        nib_ok = 1'b1;
        nib    = 4'h0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            nib = in_byte[3:0];
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            nib = in_byte[3:0] + 4'd9;
        end
        else
        begin
            nib_ok = 1'b0;
        end
    end

    assign cu_dig  = {cu_cur[11:0], nib};
    assign bad_dig = bad_cur | ~nib_ok;
    assign cp_pair = {1'b0, hh_cur[9:0], cu_dig[9:0]} + 21'h10000;

    always_comb
    begin
        mode_next  = mode_cur;
        cnt_next   = cnt_cur;
        cu_next    = cu_cur;
        hh_next    = hh_cur;
        bad_next   = bad_cur;
        push       = 1'b0;
        push_entry = fail_entry(ST_DATA);
        case (mode_cur)
            MODE_BODY:
            begin
                if (end_of_text)
                begin
                    push = 1'b1; push_entry = fail_entry(ST_EOI); mode_next = MODE_HALTED;
                end
                else if (in_byte == 8'h22)
                begin
                    push = 1'b1; push_entry = fail_entry(ST_DONE); mode_next = MODE_HALTED;
                end
                else if (in_byte == 8'h5C)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    push = 1'b1; push_entry.bytes[0] = in_byte;
                end
            end
            MODE_ESCAPE:
            begin
                push      = 1'b1;
                mode_next = MODE_BODY;
                if (end_of_text)
                begin
                    push_entry = fail_entry(ST_EOI); mode_next = MODE_HALTED;
                end
                else
                begin
                    case (in_byte)
                        8'h22, 8'h5C, 8'h2F: push_entry.bytes[0] = in_byte;
                        8'h62: push_entry.bytes[0] = 8'h08;
                        8'h66: push_entry.bytes[0] = 8'h0C;
                        8'h6E: push_entry.bytes[0] = 8'h0A;
                        8'h72: push_entry.bytes[0] = 8'h0D;
                        8'h74: push_entry.bytes[0] = 8'h09;
                        8'h75:
                        begin
                            push = 1'b0; mode_next = MODE_HEX;
                            cnt_next = 2'd0; cu_next = 16'h0000; bad_next = 1'b0;
                        end
                        default:
                        begin
                            push_entry = fail_entry(ST_ESC); mode_next = MODE_HALTED;
                        end
                    endcase
                end
            end
            MODE_HEX, MODE_HEX_LOW:
            begin
                if (end_of_text)
                begin
                    push = 1'b1; push_entry = fail_entry(ST_EOI); mode_next = MODE_HALTED;
                end
                else
                begin
                    cu_next  = cu_dig;
                    bad_next = bad_dig;
                    cnt_next = cnt_cur + 2'd1;
                    if (cnt_cur == 2'd3)
                    begin
                        push = 1'b1;
                        if (mode_cur == MODE_HEX)
                        begin
                            if (bad_dig)
                            begin
                                push_entry = fail_entry(ST_ESC); mode_next = MODE_HALTED;
                            end
                            else if (cu_dig[15:10] == 6'b110110)
                            begin
                                push = 1'b0; hh_next = cu_dig; mode_next = MODE_WANT_BS;
                            end
                            else
                            begin
                                push_entry = utf8_enc({5'b00000, cu_dig}); mode_next = MODE_BODY;
                            end
                        end
                        else if (bad_dig || cu_dig[15:10] != 6'b110111)
                        begin
                            push_entry = fail_entry(ST_ESC); mode_next = MODE_HALTED;
                        end
                        else
                        begin
                            push_entry = utf8_enc(cp_pair); mode_next = MODE_BODY;
                        end
                    end
                end
            end
            MODE_WANT_BS:
            begin
                if (end_of_text || in_byte != 8'h5C)
                begin
                    push = 1'b1; push_entry = fail_entry(ST_ESC); mode_next = MODE_HALTED;
                end
                else
                begin
                    mode_next = MODE_WANT_U;
                end
            end
            MODE_WANT_U:
            begin
                if (end_of_text || in_byte != 8'h75)
                begin
                    push = 1'b1; push_entry = fail_entry(ST_ESC); mode_next = MODE_HALTED;
                end
                else
                begin
                    mode_next = MODE_HEX_LOW;
                    cnt_next = 2'd0; cu_next = 16'h0000; bad_next = 1'b0;
                end
            end
            default:
            begin
                mode_next = MODE_HALTED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BODY;
            cnt_reg  <= 2'd0;
            cu_reg   <= 16'h0000;
            hh_reg   <= 16'h0000;
            bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            cu_reg   <= cu_next;
            hh_reg   <= hh_next;
            bad_reg  <= bad_next;
        end
    end

endmodule

// ===== rtl/core/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Short entry queue between the decoder and the byte serialiser.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  jsu_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output jsu_entry_t head_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    jsu_entry_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Byte serialiser: walks the bytes of the head entry into a registered
// output stage, one byte per transfer, marking the entry's final byte.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  jsu_entry_t head_entry,
    output logic       pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic [1:0] m_axis_tuser,
    output logic       m_axis_tlast
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;
    logic       last_reg;
    logic       load, at_end;

    assign load   = head_valid & (~valid_reg | m_axis_tready);
    assign at_end = (idx_reg == head_entry.last_idx);
    assign pop    = load & at_end;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= head_entry.bytes[idx_reg];
            status_reg <= head_entry.status;
            last_reg   <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

endmodule
